[hw/rtl/bps_pkg.sv]
// Shared constants, types and the entry compare for the best path selector.
package bps_pkg;

  localparam int NUM_PATHS   = 16;
  localparam int IDX_W       = $clog2(NUM_PATHS);
  localparam int SLOT_W      = 4;
  localparam int PRIO_W      = 32;
  localparam int RTT_W       = 16;
  localparam logic [RTT_W-1:0] MARGIN_RST = RTT_W'(10);
  localparam logic [1:0] WS_UNRELIABLE = 2'd1;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SELECT = 2'd2,
    CMD_EVAL   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              writable;
    logic [1:0]        wstate;
    logic              receiving;
    logic [PRIO_W-1:0] prio;
    logic [RTT_W-1:0]  rtt;
  } entry_t;

  // running best candidate handed from cell to cell
  typedef struct packed {
    logic              tok;
    logic              have;
    logic [IDX_W-1:0]  idx;
    entry_t            ent;
    logic [RTT_W-1:0]  sel_rtt;
  } cand_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } sel_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] slot;
    entry_t            ent;
  } wr_t;

  // true when x is strictly preferred over y
  function automatic logic better(entry_t x, entry_t y);
    logic r;
    if (x.writable != y.writable)
      r = x.writable;
    else if (x.wstate != y.wstate)
      r = (x.wstate < y.wstate);
    else if (x.receiving != y.receiving)
      r = x.receiving;
    else if (x.prio != y.prio)
      r = (x.prio > y.prio);
    else
      r = (x.rtt < y.rtt);
    return r;
  endfunction

endpackage

[hw/rtl/bps_if.sv]
// Request channel interfaces: command input, result output, configuration write.
interface bps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  slot;
  logic        path_writable;
  logic [1:0]  path_wstate;
  logic        path_receiving;
  logic [31:0] path_priority;
  logic [15:0] path_rtt_ms;

  modport source (output valid, command, slot, path_writable, path_wstate,
                  path_receiving, path_priority, path_rtt_ms, input ready);
  modport sink (input valid, command, slot, path_writable, path_wstate,
                path_receiving, path_priority, path_rtt_ms, output ready);
endinterface

interface bps_out_if;
  logic       valid;
  logic       ready;
  logic       switch_found;
  logic [3:0] switch_slot;
  logic       status;

  modport source (output valid, switch_found, switch_slot, status, input ready);
  modport sink (input valid, switch_found, switch_slot, status, output ready);
endinterface

interface bps_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[hw/rtl/bps_cell.sv]
// One table slot: holds an entry and folds it into the passing best candidate.
module bps_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bps_pkg::IDX_W-1:0]   cell_idx,
  input  bps_pkg::wr_t                wr,
  input  bps_pkg::sel_t               sel,
  input  bps_pkg::cand_t              cand_in,
  output bps_pkg::cand_t              cand_out,
  output logic                        valid_out
);
  import bps_pkg::*;

  logic   hit;
  logic   valid_r, valid_nxt;
  entry_t ent_r;
  cand_t  cand_r, cand_nxt;

  assign hit = (32'(wr.slot) == 32'(cell_idx));

  always_comb begin
    valid_nxt = valid_r;
    if (wr.we && hit)
      valid_nxt = 1'b1;
    else if (wr.re && hit)
      valid_nxt = 1'b0;
  end

  always_comb begin
    cand_nxt = cand_in;
    // strict compare keeps the lower slot on a tie
    if (valid_r && (!cand_in.have || better(ent_r, cand_in.ent))) begin
      cand_nxt.have = 1'b1;
      cand_nxt.idx  = cell_idx;
      cand_nxt.ent  = ent_r;
    end
    if (valid_r && sel.valid && (sel.idx == cell_idx))
      cand_nxt.sel_rtt = ent_r.rtt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cand_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      cand_r  <= cand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we && hit)
      ent_r <= wr.ent;
  end

  assign cand_out  = cand_r;
  assign valid_out = valid_r;

endmodule

[hw/rtl/bps_ctrl.sv]
// Command decode, selection and margin registers, scan sequencing, result register.
module bps_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  bps_in_if.sink                             in_ch,
  bps_out_if.source                          out_ch,
  bps_cfg_if.sink                            cfg_ch,
  input  logic [bps_pkg::NUM_PATHS-1:0]      valid_vec,
  input  bps_pkg::cand_t                     tail,
  output bps_pkg::cand_t                     head,
  output bps_pkg::wr_t                       wr,
  output bps_pkg::sel_t                      sel
);
  import bps_pkg::*;

  state_t state_r, state_nxt;
  cmd_t   cmd;
  logic   acc, in_range, slot_valid, out_free, load_imm, load_eval;
  logic   ready_ok, same, go, found;
  logic   sel_valid_r, sel_valid_nxt;
  logic [IDX_W-1:0]  sel_idx_r, sel_idx_nxt;
  logic [RTT_W-1:0]  margin_r;
  logic              res_found_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              out_valid_r, out_valid_nxt;
  logic              found_r, status_r;
  logic [SLOT_W-1:0] sw_slot_r;

  assign cmd      = cmd_t'(in_ch.command);
  assign acc      = in_ch.valid && in_ch.ready;
  assign in_range = (32'(in_ch.slot) < NUM_PATHS);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    slot_valid = 1'b0;
    for (int i = 0; i < NUM_PATHS; i++) begin
      if (32'(in_ch.slot) == i)
        slot_valid = valid_vec[i];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (acc && cmd == CMD_EVAL) state_nxt = S_SCAN;
      S_SCAN: if (tail.tok) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = 1'b0;
    load_eval   = 1'b0;
    unique case (state_r)
      S_IDLE: in_ch.ready = out_free;
      S_SCAN: ;
      S_DONE: load_eval = out_free;
      default: ;
    endcase
  end

  assign load_imm = acc && (cmd != CMD_EVAL);

  always_comb begin
    head         = '0;
    head.tok     = acc && (cmd == CMD_EVAL);
    wr.we        = acc && (cmd == CMD_WRITE) && in_range;
    wr.re        = acc && (cmd == CMD_REMOVE) && in_range;
    wr.slot      = in_ch.slot;
    wr.ent.writable    = in_ch.path_writable;
    wr.ent.wstate      = in_ch.path_wstate;
    wr.ent.receiving   = in_ch.path_receiving;
    wr.ent.prio        = in_ch.path_priority;
    wr.ent.rtt         = in_ch.path_rtt_ms;
  end

  assign sel.valid = sel_valid_r;
  assign sel.idx   = sel_idx_r;

  always_comb begin
    sel_valid_nxt = sel_valid_r;
    sel_idx_nxt   = sel_idx_r;
    if (acc && in_range && slot_valid) begin
      if (cmd == CMD_REMOVE && sel_valid_r && (32'(sel_idx_r) == 32'(in_ch.slot))) begin
        sel_valid_nxt = 1'b0;
        sel_idx_nxt   = '0;
      end else if (cmd == CMD_SELECT) begin
        sel_valid_nxt = 1'b1;
        sel_idx_nxt   = IDX_W'(in_ch.slot);
      end
    end
  end

  // decision at the end of the chain
  assign ready_ok = tail.ent.writable || (tail.ent.wstate == WS_UNRELIABLE);
  assign same     = sel_valid_r && (sel_idx_r == tail.idx);
  assign go       = !sel_valid_r ||
                    ({1'b0, tail.ent.rtt} + {1'b0, margin_r} <= {1'b0, tail.sel_rtt});
  assign found    = tail.have && ready_ok && !same && go;

  assign out_valid_nxt = (load_imm || load_eval) ? 1'b1 :
                         (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_valid_r <= 1'b0;
      sel_idx_r   <= '0;
      margin_r    <= MARGIN_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_valid_r <= sel_valid_nxt;
      sel_idx_r   <= sel_idx_nxt;
      if (cfg_ch.valid && cfg_ch.ready)
        margin_r <= cfg_ch.data;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SCAN && tail.tok) begin
      res_found_r <= found;
      res_slot_r  <= found ? SLOT_W'(tail.idx) : '0;
    end
    if (load_imm) begin
      found_r   <= 1'b0;
      sw_slot_r <= '0;
      status_r  <= (cmd != CMD_WRITE) && !(in_range && slot_valid);
    end else if (load_eval) begin
      found_r   <= res_found_r;
      sw_slot_r <= res_slot_r;
      status_r  <= 1'b0;
    end
  end

  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.switch_found = found_r;
  assign out_ch.switch_slot  = sw_slot_r;
  assign out_ch.status       = status_r;

endmodule

[hw/rtl/best_path_selector_top.sv]
// Best path selector: controller plus a chain of table cells.
//
//   channel   dir   handshake       payload
//   in_ch     in    valid/ready     command, slot, path_* entry fields
//   out_ch    out   valid/ready     switch_found, switch_slot, status
//   cfg_ch    in    valid/ready     data = min_rtt_improvement (ready tied high)
//
// Write, remove and select load the result at once; evaluate passes the best
// candidate through one register per cell, then decides and loads the result.
// rst_n is synchronous: clears all entry valid bits, the selection, the margin
// to 10. Idle takes a request while the result register is free or being read.
module best_path_selector_top (
  input  logic      clk,
  input  logic      rst_n,
  bps_in_if.sink    in_ch,
  bps_out_if.source out_ch,
  bps_cfg_if.sink   cfg_ch
);
  import bps_pkg::*;

  cand_t                 chain [NUM_PATHS+1];
  logic [NUM_PATHS-1:0]  valid_vec;
  wr_t                   wr;
  sel_t                  sel;

  bps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .valid_vec (valid_vec),
    .tail      (chain[NUM_PATHS]),
    .head      (chain[0]),
    .wr        (wr),
    .sel       (sel)
  );

  for (genvar gi = 0; gi < NUM_PATHS; gi++) begin : g_cell
    bps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(gi)),
      .wr        (wr),
      .sel       (sel),
      .cand_in   (chain[gi]),
      .cand_out  (chain[gi+1]),
      .valid_out (valid_vec[gi])
    );
  end

endmodule
